>>> design/bcomp_pkg.sv
// Shared constants and types for the barometric compensation pipeline.
`default_nettype none

package bcomp_pkg;

	localparam int DIV_W     = 64;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_W     = 48;

	// Register indexes on the configuration channel.
	localparam logic [CFG_IDX_W-1:0] REG_TEMP   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_P123   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_P456   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_P789   = 8'd3;

	localparam logic signed [32:0] T_OFFSET   = 33'sd128000;
	localparam logic [20:0]        P_BASE     = 21'd1048576;
	localparam logic [12:0]        P_SCALE    = 13'd3125;

	// Front stages, divider (sign stage, one stage per quotient bit, output), back stages.
	localparam int LATENCY = 11 + DIV_W + 2 + 5;

	typedef struct packed {
		logic signed [31:0] tf;
		logic signed [31:0] tc;
		logic               inv;
	} bcomp_side_t;

endpackage

`default_nettype wire

>>> design/bcomp_div.sv
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating toward zero.
`default_nettype none

module bcomp_div
	import bcomp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [DIV_W-1:0]  num,
	input  wire logic [DIV_W-1:0]  den,
	input  wire bcomp_side_t       in_side,
	output logic                   out_valid,
	output logic [DIV_W-1:0]       quo,
	output bcomp_side_t            out_side
);

	logic [DIV_W+1:0] vld_s;
	logic [DIV_W-1:0] rem_s  [0:DIV_W];
	logic [DIV_W-1:0] dvd_s  [0:DIV_W];
	logic [DIV_W-1:0] den_s  [0:DIV_W];
	logic             neg_s  [0:DIV_W];
	bcomp_side_t      side_s [0:DIV_W];
	logic [DIV_W-1:0] quo_q;
	bcomp_side_t      side_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[DIV_W:0], in_valid};
		end
	end

	// Magnitudes and result sign enter the array.
	always_ff @(posedge clk) begin
		rem_s[0]  <= '0;
		dvd_s[0]  <= num[DIV_W-1] ? (~num + 1'b1) : num;
		den_s[0]  <= den[DIV_W-1] ? (~den + 1'b1) : den;
		neg_s[0]  <= num[DIV_W-1] ^ den[DIV_W-1];
		side_s[0] <= in_side;
	end

	for (genvar k = 0; k < DIV_W; k++) begin : g_step
		logic [DIV_W:0]   trial;
		logic [DIV_W+1:0] diff;
		logic             ge;

		always_comb begin
			trial = {rem_s[k], dvd_s[k][DIV_W-1]};
			diff  = {1'b0, trial} - {2'b00, den_s[k]};
			ge    = !diff[DIV_W+1];
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			dvd_s[k+1]  <= {dvd_s[k][DIV_W-2:0], ge};
			den_s[k+1]  <= den_s[k];
			neg_s[k+1]  <= neg_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	always_ff @(posedge clk) begin
		quo_q  <= neg_s[DIV_W] ? (~dvd_s[DIV_W] + 1'b1) : dvd_s[DIV_W];
		side_q <= side_s[DIV_W];
	end

	assign out_valid = vld_s[DIV_W+1];
	assign quo       = quo_q;
	assign out_side  = side_q;

endmodule

`default_nettype wire

>>> design/baro_temp_press_compensation.sv
// Top level of the barometric temperature and pressure compensation pipeline.
//
// Usage: write the four calibration registers over the cfg_* channel (index 0 temperature
// coefficients, 1..3 pressure coefficients; other indexes are ignored; cfg_ready is always
// high). Then raise start with raw_temperature and raw_pressure; a transfer happens at each
// clock edge with start high and busy low. One sample set can be taken every cycle
// while busy is low. Each sample set gives one result on fine_temperature,
// temperature_centi, pressure_q24_8 and pressure_invalid, marked by a one-cycle done
// strobe, in order. The delay is set by the pressure divider (one quotient bit per
// stage) plus the multiplier stages around it.
// A zero pressure divisor gives pressure_invalid high and pressure_q24_8 zero.
// Reset clears all calibration registers and drops every item in flight; busy is high
// during reset and is cleared by the clock after it. The receiver cannot hold results off,
// so the pipeline never stalls.
`default_nettype none

module baro_temp_press_compensation
	import bcomp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [19:0]          raw_temperature,
	input  wire logic [19:0]          raw_pressure,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output logic                      done,
	output logic signed [31:0]        fine_temperature,
	output logic signed [31:0]        temperature_centi,
	output logic [31:0]               pressure_q24_8,
	output logic                      pressure_invalid
);

	logic             busy_q;
	logic [CFG_W-1:0] temp_q, p123_q, p456_q, p789_q;
	logic             accept;

	assign accept    = start && !busy_q;
	assign busy      = busy_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			temp_q <= '0;
			p123_q <= '0;
			p456_q <= '0;
			p789_q <= '0;
		end else begin
			busy_q <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					REG_TEMP: temp_q <= cfg_data;
					REG_P123: p123_q <= cfg_data;
					REG_P456: p456_q <= cfg_data;
					REG_P789: p789_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Calibration fields. Unenforced: change registers only when the pipeline is empty.
	logic        [15:0] t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
	assign t1 = temp_q[15:0];
	assign t2 = $signed(temp_q[31:16]);
	assign t3 = $signed(temp_q[47:32]);
	assign p1 = p123_q[15:0];
	assign p2 = $signed(p123_q[31:16]);
	assign p3 = $signed(p123_q[47:32]);
	assign p4 = $signed(p456_q[15:0]);
	assign p5 = $signed(p456_q[31:16]);
	assign p6 = $signed(p456_q[47:32]);
	assign p7 = $signed(p789_q[15:0]);
	assign p8 = $signed(p789_q[31:16]);
	assign p9 = $signed(p789_q[47:32]);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic vld_s11, vld_s12, vld_s13, vld_s14, vld_s15, vld_s16;
	logic div_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8} <= '0;
			{vld_s9, vld_s10, vld_s11, vld_s12, vld_s13, vld_s14, vld_s15, vld_s16} <= '0;
		end else begin
			vld_s1  <= accept;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= div_vld;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
			vld_s15 <= vld_s14;
			vld_s16 <= vld_s15;
		end
	end

	// Temperature path, 32-bit wrapping arithmetic.
	logic signed [17:0] ta_s1;
	logic signed [16:0] d_s1;
	logic        [19:0] adcp_s1, adcp_s2, adcp_s3, adcp_s4, adcp_s5, adcp_s6, adcp_s7, adcp_s8;
	logic signed [31:0] a_s2, dd_s2, a_s3, b_s3, tf_s4;
	logic signed [33:0] ta_prod, dd_prod;
	logic signed [47:0] b_prod;
	logic signed [31:0] tc_mul;

	assign ta_prod = ta_s1 * t2;
	assign dd_prod = d_s1 * d_s1;
	assign b_prod  = (dd_s2 >>> 12) * t3;
	assign tc_mul  = tf_s4 * 32'sd5 + 32'sd128;

	always_ff @(posedge clk) begin
		ta_s1   <= $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
		d_s1    <= $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});
		adcp_s1 <= raw_pressure;

		a_s2    <= $signed(ta_prod[31:0]) >>> 11;
		dd_s2   <= dd_prod[31:0];
		adcp_s2 <= adcp_s1;

		a_s3    <= a_s2;
		b_s3    <= $signed(b_prod[31:0]) >>> 14;
		adcp_s3 <= adcp_s2;

		tf_s4   <= a_s3 + b_s3;
		adcp_s4 <= adcp_s3;
	end

	// Pressure path, 64-bit wrapping arithmetic.
	logic signed [31:0] tf_s5, tf_s6, tf_s7, tf_s8, tf_s9, tf_s10, tf_s11;
	logic signed [31:0] tc_s5, tc_s6, tc_s7, tc_s8, tc_s9, tc_s10, tc_s11;
	logic signed [32:0] x_s5;
	logic signed [65:0] xx_prod;
	logic signed [48:0] xp5_prod, xp2_prod;
	logic signed [63:0] xx_s6;
	logic signed [48:0] xp5_s6, xp2_s6, xp5_s7, xp2_s7;
	logic signed [79:0] y6_prod, z3_prod;
	logic signed [63:0] y6_s7, z3_s7, y_s8, z_s8, diff_s9, zm_s9, num_s10, zp_s10;
	logic signed [63:0] num_s11, den_s11;
	logic               inv_s11;
	logic [20:0]        pbase;
	logic [76:0]        num_prod;
	logic [79:0]        zp_prod;

	assign xx_prod  = x_s5 * x_s5;
	assign xp5_prod = x_s5 * p5;
	assign xp2_prod = x_s5 * p2;
	assign y6_prod  = xx_s6 * p6;
	assign z3_prod  = xx_s6 * p3;
	assign pbase    = P_BASE - {1'b0, adcp_s8};
	assign num_prod = $unsigned(diff_s9) * P_SCALE;
	assign zp_prod  = $unsigned(zm_s9) * p1;

	always_ff @(posedge clk) begin
		tf_s5   <= tf_s4;
		tc_s5   <= tc_mul >>> 8;
		x_s5    <= $signed({tf_s4[31], tf_s4}) - T_OFFSET;
		adcp_s5 <= adcp_s4;

		xx_s6   <= xx_prod[63:0];
		xp5_s6  <= xp5_prod;
		xp2_s6  <= xp2_prod;
		tf_s6   <= tf_s5;
		tc_s6   <= tc_s5;
		adcp_s6 <= adcp_s5;

		y6_s7   <= y6_prod[63:0];
		z3_s7   <= z3_prod[63:0];
		xp5_s7  <= xp5_s6;
		xp2_s7  <= xp2_s6;
		tf_s7   <= tf_s6;
		tc_s7   <= tc_s6;
		adcp_s7 <= adcp_s6;

		y_s8    <= y6_s7 + (64'(xp5_s7) <<< 17) + (64'(p4) <<< 35);
		z_s8    <= (z3_s7 >>> 8) + (64'(xp2_s7) <<< 12);
		tf_s8   <= tf_s7;
		tc_s8   <= tc_s7;
		adcp_s8 <= adcp_s7;

		diff_s9 <= $signed({12'd0, pbase, 31'd0}) - y_s8;
		zm_s9   <= z_s8 + (64'sd1 <<< 47);
		tf_s9   <= tf_s8;
		tc_s9   <= tc_s8;

		num_s10 <= $signed(num_prod[63:0]);
		zp_s10  <= $signed(zp_prod[63:0]);
		tf_s10  <= tf_s9;
		tc_s10  <= tc_s9;

		num_s11 <= num_s10;
		den_s11 <= zp_s10 >>> 33;
		inv_s11 <= (zp_s10[63:33] == '0);
		tf_s11  <= tf_s10;
		tc_s11  <= tc_s10;
	end

	bcomp_side_t div_side_in, div_side;
	logic [63:0] div_quo;

	assign div_side_in = '{tf: tf_s11, tc: tc_s11, inv: inv_s11};

	bcomp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s11),
		.num       (num_s11),
		.den       (den_s11),
		.in_side   (div_side_in),
		.out_valid (div_vld),
		.quo       (div_quo),
		.out_side  (div_side)
	);

	// Second-order correction on the quotient; the 64x64 square term is split into halves.
	logic signed [63:0] qv, ps;
	logic signed [79:0] m9_prod, f8_prod;
	logic signed [63:0] m9_s12, ps_s12, f8_s12, q_s12, f8_s13, q_s13, f8_s14, q_s14, e_s14;
	logic signed [63:0] sum_s15, pfin;
	logic        [63:0] ll_prod, hl_prod, lh_prod;
	logic        [63:0] ll_s13;
	logic        [31:0] hl_s13, lh_s13;
	logic        [31:0] press_s16;
	bcomp_side_t        side_s12, side_s13, side_s14, side_s15, side_s16;

	assign qv      = $signed(div_quo);
	assign ps      = qv >>> 13;
	assign m9_prod = p9 * ps;
	assign f8_prod = p8 * qv;
	assign ll_prod = m9_s12[31:0] * ps_s12[31:0];
	assign hl_prod = m9_s12[63:32] * ps_s12[31:0];
	assign lh_prod = m9_s12[31:0] * ps_s12[63:32];
	assign pfin    = (sum_s15 >>> 8) + (64'(p7) <<< 4);

	always_ff @(posedge clk) begin
		m9_s12   <= m9_prod[63:0];
		f8_s12   <= f8_prod[63:0];
		ps_s12   <= ps;
		q_s12    <= qv;
		side_s12 <= div_side;

		ll_s13   <= ll_prod;
		hl_s13   <= hl_prod[31:0];
		lh_s13   <= lh_prod[31:0];
		f8_s13   <= f8_s12;
		q_s13    <= q_s12;
		side_s13 <= side_s12;

		e_s14    <= $signed(ll_s13 + {hl_s13 + lh_s13, 32'd0});
		f8_s14   <= f8_s13;
		q_s14    <= q_s13;
		side_s14 <= side_s13;

		sum_s15  <= q_s14 + (e_s14 >>> 25) + (f8_s14 >>> 19);
		side_s15 <= side_s14;

		press_s16 <= side_s15.inv ? '0 : pfin[31:0];
		side_s16  <= side_s15;
	end

	assign done              = vld_s16;
	assign fine_temperature  = side_s16.tf;
	assign temperature_centi = side_s16.tc;
	assign pressure_q24_8    = press_s16;
	assign pressure_invalid  = side_s16.inv;

	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(LATENCY) done)
		else $error("accepted sample set did not complete on time");

	a_no_spurious : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching accepted sample set");

	a_invalid_zero : assert property (@(posedge clk) disable iff (!arst_n)
		done && pressure_invalid |-> pressure_q24_8 == '0)
		else $error("invalid pressure result is not zero");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the barometric temperature and pressure compensation block.
`default_nettype none

module tb_top;
	import bcomp_pkg::*;

	localparam int IDLE_LIMIT = 5000;

	typedef struct {
		bit signed [31:0] fine;
		bit signed [31:0] centi;
		bit [31:0]        press;
		bit               inv;
	} comp_result_t;

	class compensation_scoreboard;
		bit [CFG_W-1:0] coeff_t, coeff_p123, coeff_p456, coeff_p789;
		comp_result_t   pending_readings[$];
		int             mismatches;

		function void set_coeffs(bit [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] val);
			case (idx)
				REG_TEMP: coeff_t    = val;
				REG_P123: coeff_p123 = val;
				REG_P456: coeff_p456 = val;
				REG_P789: coeff_p789 = val;
				default: ;
			endcase
		endfunction

		// Signed 64-bit quotient, truncated toward zero; the most negative
		// dividend over minus one wraps to itself.
		function longint quot_toward_zero(longint n, longint d);
			bit [63:0] mn, md, q;
			mn = n[63] ? -n : n;
			md = d[63] ? -d : d;
			q = mn / md;
			return (n[63] ^ d[63]) ? -q : q;
		endfunction

		function comp_result_t compensate(bit [19:0] raw_t, bit [19:0] raw_p);
			comp_result_t r;
			int t1, t2, t3, adc, lin, prod, a, d, sq, b, tf, tc;
			longint p1, p2, p3, p4, p5, p6, p7, p8, p9, x, y, z, p, ps, e, f;
			adc = int'(raw_t);
			t1 = int'(coeff_t[15:0]);
			t2 = int'(signed'(coeff_t[31:16]));
			t3 = int'(signed'(coeff_t[47:32]));
			lin = (adc >>> 3) - (t1 <<< 1);
			prod = lin * t2;
			a = prod >>> 11;
			d = (adc >>> 4) - t1;
			sq = d * d;
			sq = sq >>> 12;
			prod = sq * t3;
			b = prod >>> 14;
			tf = a + b;
			prod = tf * 5 + 128;
			tc = prod >>> 8;
			p1 = longint'(coeff_p123[15:0]);
			p2 = longint'(signed'(coeff_p123[31:16]));
			p3 = longint'(signed'(coeff_p123[47:32]));
			p4 = longint'(signed'(coeff_p456[15:0]));
			p5 = longint'(signed'(coeff_p456[31:16]));
			p6 = longint'(signed'(coeff_p456[47:32]));
			p7 = longint'(signed'(coeff_p789[15:0]));
			p8 = longint'(signed'(coeff_p789[31:16]));
			p9 = longint'(signed'(coeff_p789[47:32]));
			x = longint'(tf) - 64'sd128000;
			y = x * x * p6;
			y = y + ((x * p5) <<< 17);
			y = y + (p4 <<< 35);
			z = x * x * p3;
			z = (z >>> 8) + ((x * p2) <<< 12);
			z = ((64'sd1 <<< 47) + z) * p1;
			z = z >>> 33;
			r.fine = tf;
			r.centi = tc;
			r.press = '0;
			r.inv = (z == 0);
			if (z != 0) begin
				p = 64'sd1048576 - longint'(raw_p);
				p = quot_toward_zero(((p <<< 31) - y) * 64'sd3125, z);
				ps = p >>> 13;
				e = p9 * ps * ps;
				e = e >>> 25;
				f = p8 * p;
				f = f >>> 19;
				p = p + e + f;
				p = (p >>> 8) + (p7 <<< 4);
				r.press = p[31:0];
			end
			return r;
		endfunction

		function void note_input(bit [19:0] raw_t, bit [19:0] raw_p);
			pending_readings.push_back(compensate(raw_t, raw_p));
		endfunction

		function void report(string what, longint got, longint want);
			$display("MISMATCH %s: got %0d expected %0d", what, got, want);
			mismatches++;
		endfunction

		function void check(bit signed [31:0] fine, bit signed [31:0] centi,
				bit [31:0] press, bit inv);
			comp_result_t w;
			if (pending_readings.size() == 0) begin
				report("unexpected result, fine_temperature", fine, 0);
				return;
			end
			w = pending_readings.pop_front();
			if (fine != w.fine) report("fine_temperature", fine, w.fine);
			if (centi != w.centi) report("temperature_centi", centi, w.centi);
			if (press != w.press) report("pressure_q24_8", press, w.press);
			if (inv != w.inv) report("pressure_invalid", inv, w.inv);
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [19:0]          raw_temperature = '0;
	logic [19:0]          raw_pressure = '0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 done;
	logic signed [31:0]   fine_temperature;
	logic signed [31:0]   temperature_centi;
	logic [31:0]          pressure_q24_8;
	logic                 pressure_invalid;

	compensation_scoreboard sb = new;
	int idle_pct;
	int quiet_cycles;

	baro_temp_press_compensation dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.raw_temperature(raw_temperature), .raw_pressure(raw_pressure),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .fine_temperature(fine_temperature),
		.temperature_centi(temperature_centi), .pressure_q24_8(pressure_q24_8),
		.pressure_invalid(pressure_invalid)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (start && !busy) sb.note_input(raw_temperature, raw_pressure);
		if (done) sb.check(fine_temperature, temperature_centi, pressure_q24_8, pressure_invalid);
		if (cfg_valid && cfg_ready) sb.set_coeffs(cfg_index, cfg_data);
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("baro_temp_press_compensation regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic bit [CFG_W-1:0] pack3(bit [15:0] lo, bit [15:0] mid, bit [15:0] hi);
		return {hi, mid, lo};
	endfunction

	// Caller is at a clock edge; returns at the edge where the transfer happened.
	// Each cycle the sender stays idle with a chance of idle_pct in a hundred.
	task automatic send_reading(bit [19:0] rt, bit [19:0] rp);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		raw_temperature <= rt;
		raw_pressure <= rp;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_readings.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_coeffs(bit [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_calibration(bit [CFG_W-1:0] t, bit [CFG_W-1:0] a,
			bit [CFG_W-1:0] b, bit [CFG_W-1:0] c);
		write_coeffs(REG_TEMP, t);
		write_coeffs(REG_P123, a);
		write_coeffs(REG_P456, b);
		write_coeffs(REG_P789, c);
	endtask

	// Typical calibration, nudged a little so that the pressure path stays valid.
	task automatic load_typical(int spread);
		load_calibration(
			pack3(16'(27504 + $urandom_range(2 * spread) - spread),
				16'(26435 + $urandom_range(2 * spread) - spread),
				16'(-1000 + $urandom_range(2 * spread) - spread)),
			pack3(16'(36477 + $urandom_range(2 * spread) - spread),
				16'(-10685 + $urandom_range(2 * spread) - spread),
				16'(3024 + $urandom_range(2 * spread) - spread)),
			pack3(16'(2855 + $urandom_range(2 * spread) - spread),
				16'(140 + $urandom_range(spread)), 16'(-7)),
			pack3(16'(15500 + $urandom_range(2 * spread) - spread),
				16'(-14600 + $urandom_range(2 * spread) - spread),
				16'(6000 + $urandom_range(2 * spread) - spread)));
	endtask

	task automatic corners();
		send_reading(20'h00000, 20'h00000);
		send_reading(20'hFFFFF, 20'hFFFFF);
		send_reading(20'h00000, 20'hFFFFF);
		send_reading(20'hFFFFF, 20'h00000);
		send_reading(20'h80000, 20'h7FFFF);
	endtask

	task automatic random_phase(int count, int pct);
		bit [19:0] rt, rp;
		idle_pct = pct;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(3) == 0) begin
				rt = 20'($urandom);
				rp = 20'($urandom);
			end else begin
				rt = 20'(519888 + $urandom_range(131071) - 65536);
				rp = 20'(415148 + $urandom_range(262143) - 131072);
			end
			send_reading(rt, rp);
		end
	endtask

	initial begin
		idle_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset calibration is all zero, so the pressure divisor is zero.
		corners();
		drain();
		load_typical(0);
		corners();
		send_reading(20'd519888, 20'd415148);
		send_reading(20'd440032, 20'd600000);
		send_reading(20'(27504 * 16), 20'd100);
		drain();
		load_calibration('1, '1, '1, '1);
		corners();
		drain();
		load_calibration('0, '0, '0, '0);
		send_reading(20'd519888, 20'd415148);
		drain();
		// Indexes beyond the last register must leave the calibration alone.
		load_typical(50);
		write_coeffs(8'd4, '1);
		write_coeffs(8'hFF, '1);
		send_reading(20'd519888, 20'd415148);
		send_reading(20'hFFFFF, 20'h00001);
		drain();

		load_typical(200);
		random_phase(200, 0);
		drain();
		load_typical(2000);
		random_phase(100, 64);
		// Hold off until everything in flight has come back, then resume.
		drain();
		random_phase(100, 64);
		drain();
		load_calibration(48'($urandom) << 16 | 48'($urandom),
			48'($urandom) << 16 | 48'($urandom),
			48'($urandom) << 16 | 48'($urandom),
			48'($urandom) << 16 | 48'($urandom));
		random_phase(150, 19);
		drain();
		load_typical(500);
		random_phase(230, 0);
		drain();

		repeat (LATENCY + 10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_readings.size() == 0) begin
			$display("baro_temp_press_compensation regression: pass");
		end else begin
			$display("baro_temp_press_compensation regression: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire
